// File: src/rau_pkg.sv
package rau_pkg;

    localparam int RES_NUM_WIDTH = 64;
    localparam int RES_DEN_WIDTH = 62;
    localparam int WORK_WIDTH    = 64;
    localparam int OUT_BITS      = 128;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  done;
        logic [WORK_WIDTH-1:0] value;
    } t_unit_res;

endpackage

// File: src/rau_mul.sv
module rau_mul import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic signed [OPERAND_WIDTH:0] i_x,
    input  logic signed [OPERAND_WIDTH:0] i_y,
    output logic signed [WORK_WIDTH-1:0]  o_prod
);

    localparam int PW = 2 * (OPERAND_WIDTH + 1);

    logic signed [PW-1:0]         w_prod;
    logic signed [WORK_WIDTH-1:0] r_prod;

    assign w_prod = i_x * i_y;

    // Every product of the operand range fits in 64 bits, so the cast is exact.
    always_ff @(posedge i_clk) begin
        r_prod <= WORK_WIDTH'(w_prod);
    end

    assign o_prod = r_prod;

endmodule

// File: src/rau_gcd.sv
module rau_gcd import rau_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORK_WIDTH-1:0] i_u,
    input  logic [WORK_WIDTH-1:0] i_v,
    output t_unit_res             o_res
);

    logic [WORK_WIDTH-1:0] r_u, r_v, r_g;
    logic [6:0]            r_k;
    logic                  r_busy, r_done;

    // Binary gcd: one shift or one subtract per cycle; both inputs are nonzero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_u    <= i_u;
                r_v    <= i_v;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                priority if (r_u == r_v) begin
                    r_g    <= r_u << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + 7'd1;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u > r_v) begin
                    r_u <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.value = r_g;

endmodule

// File: src/rau_div.sv
module rau_div import rau_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORK_WIDTH-1:0] i_dividend,
    input  logic [WORK_WIDTH-1:0] i_divisor,
    output t_unit_res             o_res
);

    logic [WORK_WIDTH-1:0] r_rem, r_q, r_d;
    logic [6:0]            r_cnt;
    logic                  r_busy, r_done;
    logic [WORK_WIDTH:0]   w_trial;
    logic                  w_fit;

    assign w_trial = {r_rem, r_q[WORK_WIDTH-1]};
    assign w_fit   = w_trial >= {1'b0, r_d};

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= WORK_WIDTH'(w_trial - {1'b0, r_d});
                end else begin
                    r_rem <= w_trial[WORK_WIDTH-1:0];
                end
                r_q   <= {r_q[WORK_WIDTH-2:0], w_fit};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(WORK_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.value = r_q;

endmodule

// File: src/rational_arithmetic_unit.sv
// Sequence: S_MUL0, S_MUL1, S_MUL2 and S_SUM on the shared multiplier and the sum, then the binary gcd
// (one shift or subtract per cycle), then two divisions on the shared divider,
// then the output register is loaded once the output side can take it.
// A zero numerator or a zero denominator skips the gcd and divisions.
// Items are taken one at a time: tready is high only in the idle state.
// Reset: i_rst_n is synchronous, active low; it clears the sequencer and valid.
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // mode, a_numerator, a_denominator, b_numerator, b_denominator, zero pad
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    // result_numerator, result_denominator, zero pad
    output logic [OUT_BITS-1:0]                       o_m_axis_tdata,
    // divide_by_zero
    output logic                                      o_m_axis_tuser
);

    localparam int W      = OPERAND_WIDTH;
    localparam int P_AN   = 2;
    localparam int P_AD   = P_AN + W;
    localparam int P_BN   = P_AD + W - 1;
    localparam int P_BD   = P_BN + W;

    t_state r_state, n_state;
    t_mode  r_mode;
    logic signed [W-1:0] r_an, r_bn;
    logic [W-2:0]        r_ad, r_bd;
    logic signed [WORK_WIDTH-1:0] r_p0, r_p1, w_prod, w_num;
    logic [WORK_WIDTH-1:0] r_un, r_ud, r_g;
    logic                  r_neg, r_err, r_skip;
    logic                  r_gcd_go;
    logic signed [W:0]     w_x, w_y;
    logic signed [W:0]     w_an, w_bn, w_ad, w_bd;
    logic                  w_gcd_start, w_div_start;
    logic [WORK_WIDTH-1:0] w_div_a, w_div_b;
    t_unit_res             w_gcd, w_div;
    logic                  r_o_valid, r_o_dbz;
    logic [RES_NUM_WIDTH-1:0] r_o_num;
    logic [RES_DEN_WIDTH-1:0] r_o_den;
    logic                  w_load;

    assign w_an = {r_an[W-1], r_an};
    assign w_bn = {r_bn[W-1], r_bn};
    assign w_ad = {2'b00, r_ad};
    assign w_bd = {2'b00, r_bd};

    always_comb begin
        w_x = w_an;
        w_y = w_bd;
        unique case (r_state)
            S_MUL0: begin
                w_x = w_an;
                w_y = (r_mode == MODE_MUL) ? w_bn : w_bd;
            end
            S_MUL1: begin
                w_x = w_bn;
                w_y = w_ad;
            end
            S_MUL2: begin
                w_x = w_ad;
                w_y = (r_mode == MODE_DIV) ? w_bn : w_bd;
            end
            default: begin
                w_x = w_an;
                w_y = w_bd;
            end
        endcase
    end

    rau_mul #(.OPERAND_WIDTH(W)) u_mul (
        .i_clk  (i_clk),
        .i_x    (w_x),
        .i_y    (w_y),
        .o_prod (w_prod)
    );

    always_comb begin
        unique case (r_mode)
            MODE_ADD: w_num = r_p0 + r_p1;
            MODE_SUB: w_num = r_p0 - r_p1;
            default:  w_num = r_p0;
        endcase
    end

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_u     (r_un),
        .i_v     (r_ud),
        .o_res   (w_gcd)
    );

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_res      (w_div)
    );

    assign w_load = (r_state == S_DONE) && (!r_o_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_s_axis_tvalid) n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = S_GCD;
            S_GCD: begin
                if (r_skip) n_state = S_DONE;
                else if (w_gcd.done) n_state = S_DIVN;
            end
            S_DIVN: if (w_div.done) n_state = S_DIVD;
            S_DIVD: if (w_div.done) n_state = S_DONE;
            S_DONE: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        w_gcd_start     = 1'b0;
        w_div_start     = 1'b0;
        w_div_a         = r_un;
        w_div_b         = w_gcd.value;
        unique case (r_state)
            S_GCD: begin
                // The gcd starts on the cycle after the magnitudes are formed.
                w_gcd_start = r_gcd_go && !r_skip;
                w_div_start = w_gcd.done && !r_skip;
            end
            S_DIVN: begin
                w_div_start = w_div.done;
                w_div_a     = r_ud;
                w_div_b     = r_g;
            end
            default: begin
                w_gcd_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_gcd_go  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_gcd_go <= (r_state == S_SUM);
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_mode <= t_mode'(i_s_axis_tdata[1:0]);
            r_an   <= i_s_axis_tdata[P_AN +: W];
            r_ad   <= i_s_axis_tdata[P_AD +: W-1];
            r_bn   <= i_s_axis_tdata[P_BN +: W];
            r_bd   <= i_s_axis_tdata[P_BD +: W-1];
        end
        if (r_state == S_MUL1) r_p0 <= w_prod;
        if (r_state == S_MUL2) r_p1 <= w_prod;
        if (r_state == S_SUM) begin
            r_err  <= (w_prod == '0);
            r_skip <= (w_prod == '0) || (w_num == '0);
            if (w_prod == '0 || w_num == '0) begin
                r_un  <= '0;
                r_ud  <= WORK_WIDTH'(1);
                r_neg <= 1'b0;
            end else begin
                r_un  <= w_num[WORK_WIDTH-1] ? WORK_WIDTH'(-w_num) : w_num;
                r_ud  <= w_prod[WORK_WIDTH-1] ? WORK_WIDTH'(-w_prod) : w_prod;
                r_neg <= w_num[WORK_WIDTH-1] ^ w_prod[WORK_WIDTH-1];
            end
        end
        if (r_state == S_GCD && w_gcd.done) r_g <= w_gcd.value;
        if (r_state == S_DIVN && w_div.done) r_un <= w_div.value;
        if (r_state == S_DIVD && w_div.done) r_ud <= w_div.value;
        if (w_load) begin
            r_o_num <= r_neg ? RES_NUM_WIDTH'(-r_un) : RES_NUM_WIDTH'(r_un);
            r_o_den <= r_ud[RES_DEN_WIDTH-1:0];
            r_o_dbz <= r_err;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(OUT_BITS - RES_NUM_WIDTH - RES_DEN_WIDTH){1'b0}}, r_o_den, r_o_num};
    assign o_m_axis_tuser  = r_o_dbz;

endmodule

// File: bench/tb.sv
module tb;
    import rau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  OPW         = 32;
    localparam int  IN_BITS     = ((4*OPW+7)/8)*8;
    localparam int  RANDOM_ITEMS = 1950;
    localparam int  HOLD_CYCLES = 3000;
    localparam int  DRAIN_CYCLES = 500;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [RES_NUM_WIDTH-1:0] num;
        logic [RES_DEN_WIDTH-1:0] den;
        logic                     dbz;
    } t_quotient;

    // Holds the reduced fractions still owed by the block, oldest first.
    class fraction_board;
        t_quotient pending[$];
        int        mismatches;
        int        results_seen;
        int        dbz_seen;
        int        mode_count[4];

        function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
            longint unsigned r;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        function void note_operands(t_mode mode, logic [OPW-1:0] an_bits,
                                    logic [OPW-2:0] ad_bits, logic [OPW-1:0] bn_bits,
                                    logic [OPW-2:0] bd_bits);
            longint          an, ad, bn, bd, num, den;
            longint unsigned un, ud, g;
            logic            neg;
            t_quotient       q;
            an = longint'($signed(an_bits));
            bn = longint'($signed(bn_bits));
            ad = longint'({33'd0, ad_bits});
            bd = longint'({33'd0, bd_bits});
            mode_count[mode]++;
            case (mode)
                MODE_ADD: begin num = an*bd + bn*ad; den = ad*bd; end
                MODE_SUB: begin num = an*bd - bn*ad; den = ad*bd; end
                MODE_MUL: begin num = an*bn;         den = ad*bd; end
                default:  begin num = an*bd;         den = ad*bn; end
            endcase
            if (den == 0) begin
                q.num = '0;
                q.den = 1;
                q.dbz = 1'b1;
            end else begin
                neg = (num < 0) != (den < 0);
                un  = (num < 0) ? longint'(-num) : num;
                ud  = (den < 0) ? longint'(-den) : den;
                if (un == 0) begin
                    ud  = 1;
                    neg = 1'b0;
                end else begin
                    g  = euclid(un, ud);
                    un = un / g;
                    ud = ud / g;
                end
                q.num = neg ? -un : un;
                q.den = ud[RES_DEN_WIDTH-1:0];
                q.dbz = 1'b0;
            end
            pending.push_back(q);
        endfunction

        function void check_result(logic [RES_NUM_WIDTH-1:0] num,
                                   logic [RES_DEN_WIDTH-1:0] den, logic dbz);
            t_quotient want;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %0d/%0d flag %0b",
                             $signed(num), den, dbz);
                return;
            end
            want = pending.pop_front();
            if (dbz) dbz_seen++;
            if (num !== want.num || den !== want.den || dbz !== want.dbz) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: expected %0d/%0d flag %0b, got %0d/%0d flag %0b",
                             results_seen, $signed(want.num), want.den, want.dbz,
                             $signed(num), den, dbz);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // mode, a_numerator, a_denominator, b_numerator, b_denominator
    logic [IN_BITS-1:0]   i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // result_numerator, result_denominator, zero pad
    logic [OUT_BITS-1:0]  o_m_axis_tdata;
    // divide_by_zero
    logic                 o_m_axis_tuser;

    fraction_board board;
    int     items_sent;
    logic   steady;
    logic   sending_done;
    longint cycles = 0;

    rational_arithmetic_unit #(.OPERAND_WIDTH(OPW)) DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("rational_arithmetic_unit verification failed");
            $finish;
        end
    end

    // Accepted items in both directions are observed at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            board.note_operands(t_mode'(i_s_axis_tdata[1:0]), i_s_axis_tdata[33:2],
                                i_s_axis_tdata[64:34], i_s_axis_tdata[96:65],
                                i_s_axis_tdata[127:97]);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tdata[63:0], o_m_axis_tdata[125:64], o_m_axis_tuser);
    end

    // Receiver: random stalls, none in the steady stretch, one long hold-off.
    initial begin : receiver
        int  hold;
        bit  held;
        hold = 0;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (!held && items_sent >= 300) begin
                held = 1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 31);
            end
        end
    end

    // The valid stays up after an accepted item; it drops only for an idle cycle.
    task automatic send_operands(t_mode mode, logic [OPW-1:0] an, logic [OPW-2:0] ad,
                                 logic [OPW-1:0] bn, logic [OPW-2:0] bd);
        while (!steady && $urandom_range(99) < 31) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {bd, bn, ad, an, mode};
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [OPW-1:0] pick_numerator();
        case ($urandom_range(9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000001;
            2:       return '0;
            3, 4, 5: return $urandom_range(200) - 100;
            6:       return $urandom_range(1, 12) * $urandom_range(60);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OPW-2:0] pick_denominator();
        case ($urandom_range(49))
            0:        return '0;
            1, 2:     return 31'h7fffffff;
            3, 4, 5:  return 31'd1;
            default:  return ($urandom_range(1) != 0) ? 31'($urandom_range(1, 120))
                                                      : 31'($urandom);
        endcase
    endfunction

    initial begin
        t_mode op;
        board = new();
        items_sent = 0;
        steady = 1'b0;
        sending_done = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Operand extremes for every operation.
        for (int m = 0; m < 4; m++) begin
            op = t_mode'(m);
            send_operands(op, 32'h7fffffff, 31'h7fffffff, 32'h7fffffff, 1);
            send_operands(op, 32'h80000001, 1, 32'h80000001, 31'h7fffffff);
            send_operands(op, 32'h80000000, 31'h7fffffff, 32'h80000000, 31'h7fffffff);
            send_operands(op, 3, 4, -5, 6);
        end
        send_operands(MODE_DIV, 7, 3, 0, 9);            // divide by zero
        send_operands(MODE_ADD, 7, 0, 2, 5);            // zero left denominator
        send_operands(MODE_MUL, 7, 3, 2, 0);            // zero right denominator
        send_operands(MODE_SUB, 5, 7, 5, 7);            // zero numerator
        send_operands(MODE_MUL, 0, 3, -8, 11);
        send_operands(MODE_ADD, 1, 2, -1, 2);
        send_operands(MODE_DIV, -6, 35, -10, 21);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 900 && n < 1150);
            op = t_mode'($urandom_range(3));
            send_operands(op, pick_numerator(), pick_denominator(),
                          ($urandom_range(19) == 0) ? '0 : pick_numerator(),
                          pick_denominator());
        end
        i_s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        sending_done = 1'b1;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d reduced fractions (%0d add, %0d sub, %0d mul, %0d div),",
                 board.results_seen, board.mode_count[MODE_ADD], board.mode_count[MODE_SUB],
                 board.mode_count[MODE_MUL], board.mode_count[MODE_DIV]);
        $display("%0d of them division-by-zero errors; %0d mismatches.",
                 board.dbz_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("rational_arithmetic_unit verification clean");
        end else begin
            $display("rational_arithmetic_unit verification failed");
        end
        $finish;
    end

endmodule
